### hw/rtl/soc_pkg.sv
package soc_pkg;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_ADD   = 2'd1,
		OP_QUERY = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_RADIUS = 2'd0,
		REG_STEP   = 2'd1,
		REG_TOL    = 2'd2,
		REG_SPARE  = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SQ,
		S_ROOTGO,
		S_ROOT,
		S_DIVXGO,
		S_DIVX,
		S_DIVYGO,
		S_DIVY,
		S_INC,
		S_POS,
		S_ARRIVE,
		S_CHAIN,
		S_STEP,
		S_DONE
	} state_t;

	// probe control moving down the cell row
	typedef struct packed {
		logic tok;
		logic hit;
	} probe_ctl_t;

	localparam int DIR_FRAC = 20;
	localparam int DW       = 36;  // signed width of any coordinate difference
	localparam int MAG_W    = 33;  // magnitude of a coordinate difference
	localparam int RED_W    = 31;  // magnitude after range reduction
	localparam int RAD_W    = 64;  // root radicand
	localparam int ROOT_W   = 32;
	localparam int LEN_W    = 34;  // root scaled back by up to two bits
	localparam int DVD_W    = MAG_W + DIR_FRAC;
	localparam int Q_W      = 22;  // direction magnitude, Q.20, always below 2^22
	localparam int U_W      = Q_W + 1;
	localparam int INC_W    = U_W + 13;
	localparam int TRV_W    = 36;

	// strictly inside: a^2 + b^2 < lim_sq, far offsets never count
	function automatic logic near_fn(input logic signed [DW-1:0] a,
			input logic signed [DW-1:0] b, input logic [31:0] lim_sq);
		logic signed [DW-1:0] lim;
		logic signed [41:0] aa;
		logic signed [41:0] bb;
		logic [42:0] sum;
		lim = DW'(64'sd1 << DIR_FRAC);
		aa = $signed(a[20:0]) * $signed(a[20:0]);
		bb = $signed(b[20:0]) * $signed(b[20:0]);
		sum = {1'b0, aa} + {1'b0, bb};
		if (a >= lim || a <= -lim || b >= lim || b <= -lim) begin
			return 1'b0;
		end
		return sum < {11'b0, lim_sq};
	endfunction

endpackage

### hw/rtl/soc_isqrt.sv
module soc_isqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [soc_pkg::RAD_W-1:0]    radicand,
	output logic                         done,
	output logic [soc_pkg::ROOT_W-1:0]   root
);
	import soc_pkg::*;

	logic [RAD_W-1:0]  n_q;
	logic [ROOT_W+2:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [4:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [ROOT_W+2:0] rem_next;
	logic [ROOT_W+2:0] trial;

	// two radicand bits per cycle, one root bit
	assign rem_next = {rem_q[ROOT_W:0], n_q[RAD_W-1 -: 2]};
	assign trial    = {1'b0, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[RAD_W-3:0], 2'b00};
			if (rem_next >= trial) begin
				rem_q  <= rem_next - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_next;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

### hw/rtl/soc_div.sv
module soc_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [soc_pkg::DVD_W-1:0]   dividend,
	input  logic [soc_pkg::LEN_W-1:0]   divisor,
	output logic                        done,
	output logic [soc_pkg::Q_W-1:0]     quotient
);
	import soc_pkg::*;

	localparam int CNT_W = $clog2(DVD_W);

	logic [DVD_W-1:0] dvd_q;
	logic [DVD_W-1:0] quo_q;
	logic [LEN_W-1:0] dsr_q;
	logic [LEN_W:0]   rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [LEN_W+1:0] rem_next;

	// restoring, one quotient bit a cycle
	assign rem_next = {rem_q, dvd_q[DVD_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			if (rem_next >= {2'b00, dsr_q}) begin
				rem_q <= (LEN_W+1)'(rem_next - {2'b00, dsr_q});
				quo_q <= {quo_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_next[LEN_W:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q[Q_W-1:0];
endmodule

### hw/rtl/soc_cell.sv
module soc_cell #(
	parameter int COORD_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic signed [COORD_BITS-1:0]  obs_x_in,
	input  logic signed [COORD_BITS-1:0]  obs_y_in,
	output logic signed [COORD_BITS-1:0]  obs_x_out,
	output logic signed [COORD_BITS-1:0]  obs_y_out,
	input  logic                          active,
	input  logic [31:0]                   rad_sq,
	input  soc_pkg::probe_ctl_t           ctl_in,
	input  logic signed [COORD_BITS+2:0]  px_in,
	input  logic signed [COORD_BITS+2:0]  py_in,
	output soc_pkg::probe_ctl_t           ctl_out,
	output logic signed [COORD_BITS+2:0]  px_out,
	output logic signed [COORD_BITS+2:0]  py_out
);
	import soc_pkg::*;

	localparam int PW = COORD_BITS + 3;

	logic signed [COORD_BITS-1:0] ox_q;
	logic signed [COORD_BITS-1:0] oy_q;
	logic signed [PW-1:0]         px_q;
	logic signed [PW-1:0]         py_q;
	probe_ctl_t                   ctl_q;
	logic signed [DW-1:0]         dx;
	logic signed [DW-1:0]         dy;
	logic                         hit_here;

	assign dx = {{(DW-PW){px_in[PW-1]}}, px_in}
		- {{(DW-COORD_BITS){ox_q[COORD_BITS-1]}}, ox_q};
	assign dy = {{(DW-PW){py_in[PW-1]}}, py_in}
		- {{(DW-COORD_BITS){oy_q[COORD_BITS-1]}}, oy_q};
	assign hit_here = active && ctl_in.tok && near_fn(dx, dy, rad_sq);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q.tok <= ctl_in.tok;
			ctl_q.hit <= ctl_in.hit | hit_here;
		end
	end

	always_ff @(posedge clk) begin
		px_q <= px_in;
		py_q <= py_in;
		if (load) begin
			ox_q <= obs_x_in;
			oy_q <= obs_y_in;
		end
	end

	assign obs_x_out = ox_q;
	assign obs_y_out = oy_q;
	assign ctl_out   = ctl_q;
	assign px_out    = px_q;
	assign py_out    = py_q;
endmodule

### hw/rtl/segment_obstacle_clearance_check.sv
// Segment clearance check against up to MAX_OBSTACLES point obstacles.
// Obstacles sit in a row of cells, one per cell; an add shifts the row by
// one and drops the new obstacle into the first cell, a clear just resets
// the fill count. A query measures the segment (a square root, then
// two divisions for the unit direction), then walks samples from
// the start, step_length apart. Each sample is checked against the end
// point first, then sent down the cell row, one cell per cycle, collecting
// a hit flag; at most length / step + 1 samples are walked. Clear, add
// and the unused operation answer in the cycle after they are accepted.
// Requests are taken only between queries. Coordinates are signed Q.10;
// all distances compare squared and strictly, so a sample exactly on a
// radius is clear.
module segment_obstacle_clearance_check #(
	parameter int MAX_OBSTACLES = 64,
	parameter int COORD_BITS    = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	// start_x, start_y, end_x, end_y, zero fill to bytes
	input  logic [((4*COORD_BITS+7)/8)*8-1:0]         s_tdata,
	// operation
	input  logic [1:0]                                s_tuser,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	// path_free, zero fill
	output logic [7:0]                                m_tdata,
	// status
	output logic                                      m_tuser,
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [1:0]                                cfg_index,
	input  logic [15:0]                               cfg_data
);
	import soc_pkg::*;

	localparam int CW    = COORD_BITS;
	localparam int DXW   = CW + 1;
	localparam int PW    = CW + 3;
	localparam int AW    = CW + 23;
	localparam int CNT_W = $clog2(MAX_OBSTACLES + 1);

	state_t state_q, state_d;

	// configuration
	logic [15:0] radius_q;
	logic [11:0] step_q;
	logic [11:0] tol_q;
	logic [31:0] rad_sq_q;
	logic [31:0] tol_sq_q;
	logic [11:0] step_eff;

	// request fields
	logic signed [CW-1:0] in_sx, in_sy, in_ex, in_ey;
	op_t                  in_op;
	logic                 accept;

	// query datapath
	logic signed [CW-1:0]  ex_q, ey_q;
	logic signed [DXW-1:0] dx_q, dy_q;
	logic [DXW-1:0]        absx, absy;
	logic [MAG_W-1:0]      magx, magy;
	logic [1:0]            sh;
	logic [1:0]            sh_q;
	logic [RED_W-1:0]      redx, redy;
	logic [2*RED_W-1:0]    sqx_s1, sqy_s1;
	logic [LEN_W-1:0]      len_q;
	logic signed [U_W-1:0] ux_q, uy_q;
	logic signed [INC_W-1:0] incx_q, incy_q;
	logic signed [AW-1:0]  accx_q, accy_q;
	logic signed [AW-1:0]  rndx, rndy;
	logic signed [PW-1:0]  px_q, py_q;
	logic [TRV_W-1:0]      trav_q;
	logic [TRV_W-1:0]      trav_next;
	logic signed [DW-1:0]  ax_end, ay_end;
	logic                  arrived;

	// units
	logic              sqrt_start, sqrt_done;
	logic [ROOT_W-1:0] sqrt_root;
	logic              div_start, div_done;
	logic [DVD_W-1:0]  div_dvd;
	logic [Q_W-1:0]    div_quo;
	logic              inject;

	// store
	logic [CNT_W-1:0] count_q;
	logic             full;
	logic             load;

	// output register
	logic m_tvalid_q, path_free_q, status_q;
	logic out_free;

	assign in_sx  = s_tdata[CW-1:0];
	assign in_sy  = s_tdata[2*CW-1:CW];
	assign in_ex  = s_tdata[3*CW-1:2*CW];
	assign in_ey  = s_tdata[4*CW-1:3*CW];
	assign in_op  = op_t'(s_tuser);
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;
	assign full     = count_q >= CNT_W'(MAX_OBSTACLES);
	assign load     = accept && (in_op == OP_ADD) && !full;
	assign cfg_ready = 1'b1;
	assign step_eff  = (step_q == 12'd0) ? 12'd1 : step_q;

	// configuration registers and their squares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 16'd1536;
			step_q   <= 12'd20;
			tol_q    <= 12'd10;
			rad_sq_q <= 32'd1536 * 32'd1536;
			tol_sq_q <= 32'd100;
		end else begin
			rad_sq_q <= 32'(radius_q) * 32'(radius_q);
			tol_sq_q <= 32'(tol_q) * 32'(tol_q);
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_RADIUS: radius_q <= cfg_data;
					REG_STEP:   step_q   <= cfg_data[11:0];
					REG_TOL:    tol_q    <= cfg_data[11:0];
					default: ;
				endcase
			end
		end
	end

	// segment length front end: range reduce, square
	assign absx = dx_q[DXW-1] ? DXW'(-dx_q) : dx_q;
	assign absy = dy_q[DXW-1] ? DXW'(-dy_q) : dy_q;
	assign magx = MAG_W'(absx);
	assign magy = MAG_W'(absy);
	always_comb begin
		if (magx[MAG_W-1 -: 2] == 2'b00 && magy[MAG_W-1 -: 2] == 2'b00) begin
			sh = 2'd0;
		end else if (!magx[MAG_W-1] && !magy[MAG_W-1]) begin
			sh = 2'd1;
		end else begin
			sh = 2'd2;
		end
	end
	assign redx = RED_W'(magx >> sh);
	assign redy = RED_W'(magy >> sh);

	assign div_dvd = (state_q == S_DIVYGO) ? {magy, {DIR_FRAC{1'b0}}}
		: {magx, {DIR_FRAC{1'b0}}};

	// sample position rounded to Q.10, halves up
	assign rndx = accx_q + AW'(64'sd1 <<< (DIR_FRAC - 1));
	assign rndy = accy_q + AW'(64'sd1 <<< (DIR_FRAC - 1));

	assign ax_end = {{(DW-PW){px_q[PW-1]}}, px_q} - {{(DW-CW){ex_q[CW-1]}}, ex_q};
	assign ay_end = {{(DW-PW){py_q[PW-1]}}, py_q} - {{(DW-CW){ey_q[CW-1]}}, ey_q};
	assign arrived = near_fn(ax_end, ay_end, tol_sq_q);
	assign trav_next = trav_q + TRV_W'(step_eff);

	soc_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (RAD_W'(sqx_s1) + RAD_W'(sqy_s1)),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	soc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (len_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// obstacle row
	logic signed [CW-1:0] obs_x_w [0:MAX_OBSTACLES];
	logic signed [CW-1:0] obs_y_w [0:MAX_OBSTACLES];
	logic signed [PW-1:0] px_w    [0:MAX_OBSTACLES];
	logic signed [PW-1:0] py_w    [0:MAX_OBSTACLES];
	probe_ctl_t           ctl_w   [0:MAX_OBSTACLES];
	logic [MAX_OBSTACLES-1:0] tok_vec;

	assign obs_x_w[0] = in_sx;
	assign obs_y_w[0] = in_sy;
	assign px_w[0]    = px_q;
	assign py_w[0]    = py_q;
	assign ctl_w[0]   = '{tok: inject, hit: 1'b0};

	for (genvar i = 0; i < MAX_OBSTACLES; i++) begin : g_cell
		soc_cell #(.COORD_BITS(CW)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.load      (load),
			.obs_x_in  (obs_x_w[i]),
			.obs_y_in  (obs_y_w[i]),
			.obs_x_out (obs_x_w[i+1]),
			.obs_y_out (obs_y_w[i+1]),
			.active    (CNT_W'(i) < count_q),
			.rad_sq    (rad_sq_q),
			.ctl_in    (ctl_w[i]),
			.px_in     (px_w[i]),
			.py_in     (py_w[i]),
			.ctl_out   (ctl_w[i+1]),
			.px_out    (px_w[i+1]),
			.py_out    (py_w[i+1])
		);
		assign tok_vec[i] = ctl_w[i+1].tok;
	end

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (accept && in_op == OP_QUERY) state_d = S_SQ;
			S_SQ:     state_d = S_ROOTGO;
			S_ROOTGO: state_d = S_ROOT;
			S_ROOT: begin
				if (sqrt_done) begin
					state_d = (sqrt_root == '0) ? S_INC : S_DIVXGO;
				end
			end
			S_DIVXGO: state_d = S_DIVX;
			S_DIVX:   if (div_done) state_d = S_DIVYGO;
			S_DIVYGO: state_d = S_DIVY;
			S_DIVY:   if (div_done) state_d = S_INC;
			S_INC:    state_d = S_POS;
			S_POS:    state_d = S_ARRIVE;
			S_ARRIVE: begin
				if (arrived) begin
					state_d = S_DONE;
				end else begin
					state_d = (count_q == '0) ? S_STEP : S_CHAIN;
				end
			end
			S_CHAIN: begin
				if (ctl_w[MAX_OBSTACLES].tok) begin
					state_d = ctl_w[MAX_OBSTACLES].hit ? S_DONE : S_STEP;
				end
			end
			S_STEP:   state_d = (trav_next > TRV_W'(len_q)) ? S_DONE : S_POS;
			S_DONE:   if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// sequencer: unit kicks
	always_comb begin
		sqrt_start = (state_q == S_ROOTGO);
		div_start  = (state_q == S_DIVXGO) || (state_q == S_DIVYGO);
		inject     = (state_q == S_ARRIVE) && !arrived && (count_q != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			m_tvalid_q  <= 1'b0;
			path_free_q <= 1'b0;
			status_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (accept) begin
				case (in_op)
					OP_CLEAR: count_q <= '0;
					OP_ADD:   if (!full) count_q <= count_q + CNT_W'(1);
					default: ;
				endcase
				if (in_op != OP_QUERY) begin
					m_tvalid_q  <= 1'b1;
					path_free_q <= 1'b0;
					status_q    <= (in_op == OP_ADD) && full;
				end
			end
			if (state_q == S_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
				status_q   <= 1'b0;
			end
			// verdict: free on arrival or overshoot, blocked on a hit
			if (state_q == S_ARRIVE && arrived) begin
				path_free_q <= 1'b1;
			end
			if (state_q == S_CHAIN && ctl_w[MAX_OBSTACLES].tok
					&& ctl_w[MAX_OBSTACLES].hit) begin
				path_free_q <= 1'b0;
			end
			if (state_q == S_STEP && trav_next > TRV_W'(len_q)) begin
				path_free_q <= 1'b1;
			end
		end
	end

	// query datapath
	always_ff @(posedge clk) begin
		if (accept && in_op == OP_QUERY) begin
			ex_q   <= in_ex;
			ey_q   <= in_ey;
			dx_q   <= DXW'(in_ex) - DXW'(in_sx);
			dy_q   <= DXW'(in_ey) - DXW'(in_sy);
			accx_q <= {{3{in_sx[CW-1]}}, in_sx, {DIR_FRAC{1'b0}}};
			accy_q <= {{3{in_sy[CW-1]}}, in_sy, {DIR_FRAC{1'b0}}};
			trav_q <= '0;
			ux_q   <= '0;
			uy_q   <= '0;
		end
		if (state_q == S_SQ) begin
			sqx_s1 <= redx * redx;
			sqy_s1 <= redy * redy;
			sh_q   <= sh;
		end
		if (state_q == S_ROOT && sqrt_done) begin
			len_q <= LEN_W'(sqrt_root) << sh_q;
		end
		if (state_q == S_DIVX && div_done) begin
			ux_q <= dx_q[DXW-1] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
		end
		if (state_q == S_DIVY && div_done) begin
			uy_q <= dy_q[DXW-1] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
		end
		if (state_q == S_INC) begin
			incx_q <= $signed({1'b0, step_eff}) * ux_q;
			incy_q <= $signed({1'b0, step_eff}) * uy_q;
		end
		if (state_q == S_POS) begin
			px_q <= rndx[AW-1:DIR_FRAC];
			py_q <= rndy[AW-1:DIR_FRAC];
		end
		if (state_q == S_STEP && !(trav_next > TRV_W'(len_q))) begin
			trav_q <= trav_next;
			accx_q <= accx_q + {{(AW-INC_W){incx_q[INC_W-1]}}, incx_q};
			accy_q <= accy_q + {{(AW-INC_W){incy_q[INC_W-1]}}, incy_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'b0, path_free_q};
	assign m_tuser  = status_q;

	// at most one sample travels the row
	a_one_probe: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vec)) else $error("more than one probe in cell row");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_OBSTACLES)) else $error("obstacle count overflow");

	a_probe_only_walking: assert property (@(posedge clk) disable iff (!arst_n)
		(|tok_vec) |-> (state_q == S_CHAIN)) else $error("probe outside walk");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |-> !s_tready) else $error("request taken mid query");
endmodule
